/* design/sktl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table lookup package
// Shared widths, codes, types and a helper function for the key table.
// ----------------------------------------------------------------------------
package sktl_pkg;

  // Default sizing of the table.
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned KEY_BYTES_DEF   = 8;

  // Fixed transaction field widths.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_APPEND   = 2'd1,
    ACT_LOOKUP   = 2'd2,
    ACT_RESERVED = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE          = 3'd0,
    ST_FOUND         = 3'd1,
    ST_NOT_FOUND     = 3'd2,
    ST_SIZE_MISMATCH = 3'd3,
    ST_FULL          = 3'd4
  } status_e;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  // Verdict of comparing the query against one stored record.
  typedef struct packed {
    logic size_mismatch;
    logic equal;
    logic less;
  } cmp_res_t;

  // Mask that keeps the low len bytes of a packed key.
  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (LEN_W'(b) < len) begin
        mask[8*b +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

/* design/sktl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sktl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sktl_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record comparator
// Compares the held query with one record read from the table.
// ----------------------------------------------------------------------------
module sktl_cmp #(
  parameter int unsigned KeyW = 64
) (
  input  logic [KeyW-1:0]              rec_key_i,
  input  logic [sktl_pkg::LEN_W-1:0]   rec_len_i,
  input  logic [KeyW-1:0]              qry_key_i,
  input  logic [sktl_pkg::LEN_W-1:0]   qry_len_i,
  output sktl_pkg::cmp_res_t           res_o
);

  // Keys are little-endian, so an unsigned compare orders them correctly.
  always_comb begin
    res_o.size_mismatch = (rec_len_i != qry_len_i);
    res_o.equal         = (qry_key_i == rec_key_i);
    res_o.less          = (qry_key_i <  rec_key_i);
  end

endmodule

/* design/sorted_key_table_lookup_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table lookup
// Table of ascending little-endian keys with clear, append and lookup.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one transaction with an
// action, a packed key and its byte length. The output channel (out_valid_o /
// out_stall_i) returns exactly one transaction per input: a status code, the
// matching record index and the record count after the action.
// Clear, append and any lookup that is settled without a scan (bad length or
// empty table) load their result into the output register on acceptance. A
// lookup that scans visits the records in order, as they are read one a cycle
// from the key RAM, and then passes its verdict through the holding state
// into the output register.
// The block works on one transaction at a time. A new transaction may be
// taken while the previous result still sits in the output register, as long
// as that register is being drained in the same cycle.
// Reset clears the record count, the controller and the output valid; the
// key RAM is not cleared, as only entries below the count are ever compared.
// When the receiver stalls, the result holds in the output register and a
// finished scan waits in its holding state; no transaction is lost.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_top #(
  parameter int unsigned TABLE_DEPTH = sktl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = sktl_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sktl_pkg::ACTION_W-1:0]   action_i,
  input  logic [sktl_pkg::KEY_W-1:0]      key_value_i,
  input  logic [sktl_pkg::LEN_W-1:0]      key_length_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sktl_pkg::STATUS_W-1:0]   status_o,
  output logic [sktl_pkg::INDEX_W-1:0]    match_index_o,
  output logic [sktl_pkg::COUNT_W-1:0]    record_count_o
);

  // Stored key width follows the number of key bytes.
  localparam int unsigned KeyW  = 8 * KEY_BYTES;
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntW  = KeyW + sktl_pkg::LEN_W;

  sktl_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [KeyW-1:0]   qry_key_q, qry_key_d;
  logic [sktl_pkg::LEN_W-1:0] qry_len_q, qry_len_d;
  sktl_pkg::status_e pend_status_q, pend_status_d;
  logic [AddrW-1:0]  pend_idx_q, pend_idx_d;

  logic                        out_valid_q;
  sktl_pkg::status_e           out_status_q;
  logic [sktl_pkg::INDEX_W-1:0] out_index_q;
  logic [sktl_pkg::COUNT_W-1:0] out_count_q;

  logic                        out_load;
  sktl_pkg::status_e           out_status_d;
  logic [AddrW-1:0]            out_idx_d;

  logic                        out_free;
  logic                        in_acc;
  logic                        len_ok;
  logic                        table_full;
  logic                        last_rec;
  logic [sktl_pkg::KEY_W-1:0]  key_masked;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_raddr;
  logic [EntW-1:0]             ram_wdata;
  logic [EntW-1:0]             ram_rdata;
  sktl_pkg::cmp_res_t          cmp_res;
  logic [AddrW+sktl_pkg::INDEX_W-1:0] idx_ext;
  logic [CntW+sktl_pkg::COUNT_W-1:0]  cnt_ext;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sktl_pkg::S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign len_ok     = (key_length_i != '0) &&
                      (key_length_i <= sktl_pkg::LEN_W'(KEY_BYTES));
  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign last_rec   = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign key_masked = key_value_i & sktl_pkg::key_mask(key_length_i);

  // Each RAM entry holds the length above the key bits.
  assign ram_wdata = {key_length_i, key_masked[KeyW-1:0]};
  assign ram_raddr = (state_q == sktl_pkg::S_SCAN) ? (idx_q + AddrW'(1)) : '0;

  sktl_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sktl_cmp #(
    .KeyW (KeyW)
  ) u_cmp (
    .rec_key_i (ram_rdata[KeyW-1:0]),
    .rec_len_i (ram_rdata[EntW-1:KeyW]),
    .qry_key_i (qry_key_q),
    .qry_len_i (qry_len_q),
    .res_o     (cmp_res)
  );

  // Controller: takes one transaction, scans the RAM for a lookup and hands
  // the result to the output register.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    qry_key_d     = qry_key_q;
    qry_len_d     = qry_len_q;
    pend_status_d = pend_status_q;
    pend_idx_d    = pend_idx_q;
    out_load      = 1'b0;
    out_status_d  = sktl_pkg::ST_DONE;
    out_idx_d     = '0;
    ram_we        = 1'b0;

    unique case (state_q)
      sktl_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (sktl_pkg::action_e'(action_i))
            sktl_pkg::ACT_CLEAR: begin
              count_d  = '0;
              out_load = 1'b1;
            end
            sktl_pkg::ACT_APPEND: begin
              out_load = 1'b1;
              if (!len_ok) begin
                out_status_d = sktl_pkg::ST_SIZE_MISMATCH;
              end else if (table_full) begin
                out_status_d = sktl_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            sktl_pkg::ACT_LOOKUP: begin
              if (!len_ok) begin
                out_load     = 1'b1;
                out_status_d = sktl_pkg::ST_SIZE_MISMATCH;
              end else if (count_q == '0) begin
                out_load     = 1'b1;
                out_status_d = sktl_pkg::ST_NOT_FOUND;
              end else begin
                // Record 0 is being read this cycle.
                idx_d     = '0;
                qry_key_d = key_masked[KeyW-1:0];
                qry_len_d = key_length_i;
                state_d   = sktl_pkg::S_SCAN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      sktl_pkg::S_SCAN: begin
        // The RAM data belongs to record idx_q.
        priority if (cmp_res.size_mismatch) begin
          pend_status_d = sktl_pkg::ST_SIZE_MISMATCH;
          pend_idx_d    = '0;
          state_d       = sktl_pkg::S_HOLD;
        end else if (cmp_res.equal) begin
          pend_status_d = sktl_pkg::ST_FOUND;
          pend_idx_d    = idx_q;
          state_d       = sktl_pkg::S_HOLD;
        end else if (cmp_res.less || last_rec) begin
          pend_status_d = sktl_pkg::ST_NOT_FOUND;
          pend_idx_d    = '0;
          state_d       = sktl_pkg::S_HOLD;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      sktl_pkg::S_HOLD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = pend_status_q;
          out_idx_d    = pend_idx_q;
          state_d      = sktl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sktl_pkg::S_IDLE;
      end
    endcase
  end

  // Fit the index and count to the fixed output field widths.
  assign idx_ext = {sktl_pkg::INDEX_W'(0), out_idx_d};
  assign cnt_ext = {sktl_pkg::COUNT_W'(0), count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sktl_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    qry_key_q     <= qry_key_d;
    qry_len_q     <= qry_len_d;
    pend_status_q <= pend_status_d;
    pend_idx_q    <= pend_idx_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_index_q  <= idx_ext[sktl_pkg::INDEX_W-1:0];
      out_count_q  <= cnt_ext[sktl_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign match_index_o  = out_index_q;
  assign record_count_o = out_count_q;

endmodule

/* verif/tb_sorted_key_table_lookup_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key table lookup testbench
// Sends clear, append, lookup and unused-action transactions with random gaps
// and random output stalls. A shadow copy of the key table predicts every
// result. Each result is compared with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_lookup_top;
  import sktl_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int unsigned KBYTES       = KEY_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 500;
  // A long receiver hold-off, so that the block fills up and stalls its input.
  localparam int unsigned HOLD_CYCLES  = 150;
  // The tail waits out the worst scan, which visits every record.
  localparam int unsigned TAIL_CYCLES  = DEPTH + 8;
  // The slowest correct run is about 600 transactions, each with the longest
  // gap, a full scan and the longest stall; this is many times that.
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // What one result transaction should carry.
  typedef struct {
    status_e              status;
    logic [INDEX_W-1:0]   index;
    logic [COUNT_W-1:0]   count;
  } table_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  action_e             action;
  logic [KEY_W-1:0]    key_value;
  logic [LEN_W-1:0]    key_length;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  match_index;
  logic [COUNT_W-1:0]  record_count;

  // Shadow copy of the table, updated as each input transaction is accepted.
  logic [KEY_W-1:0]    shadow_keys [DEPTH];
  logic [LEN_W-1:0]    shadow_lengths [DEPTH];
  int unsigned         shadow_count = 0;

  // Results predicted but not yet seen on the output, oldest first.
  table_result_t       awaited_results [$];

  // Keys and length of the most recent ascending run appended to the table.
  logic [KEY_W-1:0]    run_keys [$];
  logic [LEN_W-1:0]    run_length;

  int unsigned         items_sent = 0;
  int unsigned         errors = 0;
  int unsigned         status_tally [8];
  bit                  steady_flow = 1'b0;
  logic                hold_active;
  event                hold_go;

  sorted_key_table_lookup_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .key_value_i    (key_value),
    .key_length_i   (key_length),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .match_index_o  (match_index),
    .record_count_o (record_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] random64();
    return {$urandom, $urandom};
  endfunction

  // Keeps the low len bytes of a packed key. Lengths of eight or more keep
  // the whole word.
  function automatic logic [KEY_W-1:0] bytes_mask(logic [LEN_W-1:0] len);
    if (len >= 8) begin
      return '1;
    end
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic bit length_valid(logic [LEN_W-1:0] len);
    return (len >= 1) && (len <= KBYTES);
  endfunction

  // Applies one action to the shadow table and returns the result that the
  // block should give for it.
  function automatic table_result_t apply_table_action(action_e act,
                                                       logic [KEY_W-1:0] key_raw,
                                                       logic [LEN_W-1:0] len);
    table_result_t    res;
    logic [KEY_W-1:0] key;
    int unsigned      i;
    bit               stop;
    key        = key_raw & bytes_mask(len);
    res.status = ST_DONE;
    res.index  = '0;
    case (act)
      ACT_CLEAR: begin
        // The stored keys stay put; only the count goes back to zero.
        shadow_count = 0;
      end
      ACT_APPEND: begin
        // A bad length is reported before a full table.
        if (!length_valid(len)) begin
          res.status = ST_SIZE_MISMATCH;
        end else if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count]    = key;
          shadow_lengths[shadow_count] = len;
          shadow_count++;
        end
      end
      ACT_LOOKUP: begin
        if (!length_valid(len)) begin
          res.status = ST_SIZE_MISMATCH;
        end else begin
          // Walk upwards, stopping at the first record of another length,
          // at an equal key, or once the query falls below a record key.
          res.status = ST_NOT_FOUND;
          stop = 1'b0;
          for (i = 0; i < shadow_count && !stop; i++) begin
            if (shadow_lengths[i] != len) begin
              res.status = ST_SIZE_MISMATCH;
              stop = 1'b1;
            end else if (key == shadow_keys[i]) begin
              res.status = ST_FOUND;
              res.index  = INDEX_W'(i);
              stop = 1'b1;
            end else if (key < shadow_keys[i]) begin
              stop = 1'b1;
            end
          end
        end
      end
      default: begin
        // The unused action code leaves everything as it is.
      end
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // Offers one transaction after a random gap, none in steady flow, and returns
  // in the time step of its acceptance. Valid is left high, so that a following
  // transaction with no gap goes straight on; whoever pauses the flow lowers it.
  task automatic send_item(action_e act, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    key_value  <= key;
    key_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(apply_table_action(act, key, len));
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Appends size keys of one length in strictly ascending order. Junk is put
  // in the bytes above the length, as the block must ignore it. With
  // touch_ends set the run starts at zero and ends at the largest key.
  task automatic append_sorted_run(int unsigned size, logic [LEN_W-1:0] len,
                                   bit touch_ends);
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] step;
    logic [KEY_W-1:0] k;
    int unsigned      i;
    mask = bytes_mask(len);
    step = mask / (size + 1);
    k    = '0;
    run_keys.delete();
    run_length = len;
    for (i = 0; i < size; i++) begin
      if (i == 0) begin
        k = touch_ends ? '0 : random64() % (step + 1);
      end else begin
        k = k + 1 + random64() % step;
      end
      if (touch_ends && (i == size - 1)) begin
        k = mask;
      end
      run_keys.push_back(k);
      send_item(ACT_APPEND, k | (random64() & ~mask), len);
    end
  endtask

  // Looks up keys around the last run: stored keys, their neighbours, random
  // keys, keys of another length and keys of a length out of range.
  task automatic probe_run(int unsigned probes);
    int unsigned      n;
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      spare;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    for (n = 0; n < probes; n++) begin
      pick = $urandom_range(0, 9);
      len  = run_length;
      key  = random64();
      if (run_keys.size() != 0) begin
        idx = $urandom_range(0, run_keys.size() - 1);
        if (pick <= 4) begin
          key = run_keys[idx] | (random64() & ~bytes_mask(len));
        end else if (pick == 5) begin
          key = run_keys[idx] + 1;
        end else if (pick == 6) begin
          key = run_keys[idx] - 1;
        end
      end
      if (pick == 8) begin
        do begin
          len = LEN_W'($urandom_range(1, KBYTES));
        end while (len == run_length);
      end else if (pick == 9) begin
        spare = $urandom_range(0, 7);
        len = (spare == 0) ? '0 : LEN_W'(KBYTES + spare);
      end
      send_item(ACT_LOOKUP, key, len);
    end
  endtask

  // Lookups in an empty table, lengths out of range and the unused action.
  task automatic test_empty_and_bad_lengths();
    send_item(ACT_LOOKUP, '0, 4'd8);
    send_item(ACT_APPEND, '1, 4'd0);
    send_item(ACT_APPEND, 64'h1, 4'd9);
    send_item(ACT_LOOKUP, '1, 4'd15);
    send_item(ACT_RESERVED, '1, 4'd15);
    send_item(ACT_RESERVED, '0, 4'd0);
  endtask

  // A small ascending table of two-byte keys: hits at each end and in the
  // middle, misses below and between, junk above the length, wrong length.
  task automatic test_ordered_lookups();
    send_item(ACT_CLEAR, '1, 4'd15);
    send_item(ACT_APPEND, 64'hFFFF_FFFF_FFFF_0010, 4'd2);
    send_item(ACT_APPEND, 64'h0000_0000_0000_0100, 4'd2);
    send_item(ACT_APPEND, 64'h0000_0000_0000_FFFF, 4'd2);
    send_item(ACT_LOOKUP, 64'h0000_0000_0000_0010, 4'd2);
    send_item(ACT_LOOKUP, 64'h0000_0000_ABCD_0100, 4'd2);
    send_item(ACT_LOOKUP, 64'h0000_0000_0000_00FF, 4'd2);
    send_item(ACT_LOOKUP, 64'h0000_0000_0000_0005, 4'd2);
    send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2);
    send_item(ACT_LOOKUP, 64'h0000_0000_0000_0100, 4'd3);
  endtask

  // Records of differing lengths: a scan that passes the first record runs
  // into a size mismatch further on, and a clear empties the table.
  task automatic test_mixed_lengths();
    send_item(ACT_CLEAR, '0, 4'd0);
    send_item(ACT_APPEND, '0, 4'd8);
    send_item(ACT_APPEND, 64'h1234, 4'd4);
    send_item(ACT_LOOKUP, 64'h5, 4'd8);
    send_item(ACT_LOOKUP, '0, 4'd8);
    send_item(ACT_LOOKUP, 64'h1234, 4'd4);
    send_item(ACT_CLEAR, '1, 4'd8);
    send_item(ACT_LOOKUP, 64'h1234, 4'd4);
  endtask

  // The receiver holds off for a long stretch while transactions keep coming
  // back to back, so the block fills up and must stall its input.
  task automatic test_output_hold();
    wait_for_results();
    steady_flow = 1'b1;
    -> hold_go;
    send_item(ACT_CLEAR, '0, 4'd1);
    append_sorted_run(4, 4'd4, 1'b1);
    probe_run(8);
    steady_flow = 1'b0;
    wait_for_results();
  endtask

  // Fills the table from key zero to the largest key, then appends past the
  // end and scans the longest way.
  task automatic test_full_table();
    send_item(ACT_CLEAR, random64(), 4'd0);
    append_sorted_run(DEPTH, LEN_W'(KBYTES), 1'b1);
    send_item(ACT_APPEND, random64(), LEN_W'(KBYTES));
    send_item(ACT_APPEND, random64(), 4'd0);
    send_item(ACT_LOOKUP, run_keys[DEPTH-1], LEN_W'(KBYTES));
    send_item(ACT_LOOKUP, run_keys[0], LEN_W'(KBYTES));
    probe_run(10);
  endtask

  // Mostly well-formed sequences: a clear, an ascending run, then lookups
  // around it. The rest is noise of any action, key and length.
  task automatic test_random_sequences(int unsigned target);
    int unsigned goal;
    int unsigned size;
    goal = items_sent + target;
    while (items_sent < goal) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 7) != 0) begin
          send_item(ACT_CLEAR, random64(), LEN_W'($urandom_range(0, 15)));
        end
        size = ($urandom_range(0, 5) == 0) ? DEPTH : $urandom_range(1, 10);
        append_sorted_run(size, LEN_W'($urandom_range(1, KBYTES)),
                          $urandom_range(0, 5) == 0);
        if (size == DEPTH) begin
          send_item(ACT_APPEND, random64(), run_length);
        end
        probe_run($urandom_range(4, 12));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(action_e'($urandom_range(0, 3)), random64(),
                    LEN_W'($urandom_range(0, 15)));
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // Receiver: stalls for a random number of cycles after each result, and
  // throughout a hold-off, and checks every result that it accepts.
  initial begin : result_sink
    int unsigned   stall_left;
    table_result_t want;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: status %0d index %0d count %0d",
                   $time, status, match_index, record_count);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          status_tally[want.status]++;
          if (status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
            errors++;
          end
          if (match_index !== want.index) begin
            $display("%0t: match_index expected %0d, actual %0d",
                     $time, want.index, match_index);
            errors++;
          end
          if (record_count !== want.count) begin
            $display("%0t: record_count expected %0d, actual %0d",
                     $time, want.count, record_count);
            errors++;
          end
        end
        stall_left = steady_flow ? 0 : $urandom_range(0, 7);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= hold_active || (stall_left != 0);
    end
  end

  // Counts out the long hold-off once it has been called for.
  initial begin : hold_off
    hold_active <= 1'b0;
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycles, awaited_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    action     <= ACT_CLEAR;
    key_value  <= '0;
    key_length <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_bad_lengths();
    test_ordered_lookups();
    test_mixed_lengths();
    test_output_hold();
    test_full_table();
    test_random_sequences(RANDOM_ITEMS);

    // Let the last scan finish and catch any result that should not come.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      errors++;
    end

    $display("Ran %0d transactions of clear, append, lookup and the unused action.",
             items_sent);
    $display("Outcomes: found %0d, not found %0d, size mismatch %0d, full %0d, done %0d.",
             status_tally[ST_FOUND], status_tally[ST_NOT_FOUND],
             status_tally[ST_SIZE_MISMATCH], status_tally[ST_FULL], status_tally[ST_DONE]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
